/* sv/dft_pkg.sv */
// Shared types and constants for the dedup flow table.
// Used by dft_ctrl, dft_dpath and dedup_flow_table_core.
package dft_pkg;

  localparam int KEY_HI_W = 40;
  localparam int KEY_LO_W = 64;
  localparam int KEY_W    = KEY_HI_W + KEY_LO_W;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_GET = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic accept;      // latch input item, rewind scan index
    logic scan_rd;     // read entry at scan index, advance index
    logic get_rd;      // read entry at read pointer
    logic commit_add;  // write key at write pointer, result added=1
    logic commit_dup;  // result added=0
    logic commit_get;  // result from read entry, advance read pointer if found
    logic load_out;    // move result into output register
  } dft_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;         // previously read entry equals the key
    logic scan_last;   // scan index at last entry
    logic out_busy;    // output register full and not being taken
  } dft_sts_t;

endpackage

/* sv/dedup_flow_table_core.sv */
// Top level of the dedup flow table: controller plus datapath.
// Depends on dft_pkg, dft_ctrl, dft_dpath (and dft_ram below it).
//
// Usage: in_* carries commands (in_cmd add or get, with a 104-bit key split
// in in_key_high / in_key_low). Each accepted command yields exactly one
// transfer on out_*: added for add, found plus flow key for get.
// One command is worked at a time; in_ready is high only while idle.
// A get reads the entry at the read pointer. For an add, the entry RAM has
// one read port, so duplicate search reads one entry per cycle and stops
// early on a match.
// A new command is taken once the result has entered the output register.
// Reset (synchronous, rst_n low): pointers cleared, every table entry
// marked empty (reads as zero), no result pending. No clearing pass.
// Receiver stall: the result waits in the output register; the next
// command may already be accepted and searched, and its result waits in
// a holding register until the output register empties.
module dedup_flow_table_core #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_cmd,
  input  logic [dft_pkg::KEY_HI_W-1:0] in_key_high,
  input  logic [dft_pkg::KEY_LO_W-1:0] in_key_low,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_added,
  output logic                         out_found,
  output logic [dft_pkg::KEY_HI_W-1:0] out_flow_high,
  output logic [dft_pkg::KEY_LO_W-1:0] out_flow_low
);
  import dft_pkg::*;

  dft_cmd_t cmd;
  dft_sts_t sts;

  dft_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dft_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_cmd        (in_cmd),
    .in_key_high   (in_key_high),
    .in_key_low    (in_key_low),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_added     (out_added),
    .out_found     (out_found),
    .out_flow_high (out_flow_high),
    .out_flow_low  (out_flow_low)
  );

  a_added_found_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_added && out_found))
    else $error("added and found both set");

  a_empty_flow_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_flow_high == '0 && out_flow_low == '0))
    else $error("flow key nonzero without found");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second command taken while one is in progress");

endmodule

/* sv/dft_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/dft_ctrl.sv */
// Sequencing state machine for the dedup flow table.
// Depends on dft_pkg; drives dft_dpath through dft_cmd_t / dft_sts_t.
module dft_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_cmd,
  output logic              in_ready,
  input  dft_pkg::dft_sts_t sts,
  output dft_pkg::dft_cmd_t cmd
);
  import dft_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_GET_RD   = 6'b000010,
    S_GET_EV   = 6'b000100,
    S_SCAN     = 6'b001000,
    S_SCAN_END = 6'b010000,
    S_OUT      = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_cmd == CMD_GET) begin
            state_nxt = S_GET_RD;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_GET_RD: begin
        cmd.get_rd = 1'b1;
        state_nxt  = S_GET_EV;
      end
      S_GET_EV: begin
        cmd.commit_get = 1'b1;
        state_nxt      = S_OUT;
      end
      S_SCAN: begin
        priority if (sts.hit) begin
          cmd.commit_dup = 1'b1;
          state_nxt      = S_OUT;
        end else if (sts.scan_last) begin
          cmd.scan_rd = 1'b1;
          state_nxt   = S_SCAN_END;
        end else begin
          cmd.scan_rd = 1'b1;
        end
      end
      S_SCAN_END: begin
        if (sts.hit) begin
          cmd.commit_dup = 1'b1;
        end else begin
          cmd.commit_add = 1'b1;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sv/dft_dpath.sv */
// Datapath of the dedup flow table: key latch, entry RAM, valid bits,
// pointers, compare and output register. Depends on dft_pkg and dft_ram.
module dft_dpath #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dft_pkg::dft_cmd_t              cmd,
  output dft_pkg::dft_sts_t              sts,
  input  logic                           in_cmd,
  input  logic [dft_pkg::KEY_HI_W-1:0]   in_key_high,
  input  logic [dft_pkg::KEY_LO_W-1:0]   in_key_low,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_added,
  output logic                           out_found,
  output logic [dft_pkg::KEY_HI_W-1:0]   out_flow_high,
  output logic [dft_pkg::KEY_LO_W-1:0]   out_flow_low
);
  import dft_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  logic [KEY_HI_W-1:0]      key_hi_r;
  logic [KEY_LO_W-1:0]      key_lo_r;
  logic [IDX_W-1:0]         idx_r;
  logic [IDX_W-1:0]         wr_ptr_r, rd_ptr_r;
  logic [TABLE_ENTRIES-1:0] vld_r;
  logic                     rd_pend_r;
  logic                     rvld_r;
  logic                     res_added_r, res_found_r;
  logic [KEY_HI_W-1:0]      res_hi_r;
  logic [KEY_LO_W-1:0]      res_lo_r;
  logic                     out_valid_r;
  logic                     out_added_r, out_found_r;
  logic [KEY_HI_W-1:0]      out_hi_r;
  logic [KEY_LO_W-1:0]      out_lo_r;

  logic                     ram_re;
  logic [IDX_W-1:0]         ram_raddr;
  logic [KEY_W-1:0]         ram_rdata;
  logic [KEY_HI_W-1:0]      ent_hi;
  logic [KEY_LO_W-1:0]      ent_lo;
  logic                     ent_nz;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
    wrap_inc = (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  assign ram_re    = cmd.scan_rd | cmd.get_rd;
  assign ram_raddr = cmd.get_rd ? rd_ptr_r : idx_r;

  dft_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.commit_add),
    .waddr (wr_ptr_r),
    .wdata ({key_hi_r, key_lo_r}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // never-written entries read as zero
  assign ent_hi = rvld_r ? ram_rdata[KEY_W-1:KEY_LO_W] : '0;
  assign ent_lo = rvld_r ? ram_rdata[KEY_LO_W-1:0]     : '0;
  assign ent_nz = (ent_hi != '0) || (ent_lo != '0);

  assign sts.hit       = rd_pend_r && (ent_hi == key_hi_r) && (ent_lo == key_lo_r);
  assign sts.scan_last = (idx_r == LAST_IDX);
  assign sts.out_busy  = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rvld_r <= vld_r[ram_raddr];
    end
    if (cmd.accept) begin
      key_hi_r <= in_cmd == CMD_ADD ? in_key_high : '0;
      key_lo_r <= in_cmd == CMD_ADD ? in_key_low  : '0;
    end
    if (cmd.commit_add) begin
      res_added_r <= 1'b1;
      res_found_r <= 1'b0;
      res_hi_r    <= '0;
      res_lo_r    <= '0;
    end else if (cmd.commit_dup) begin
      res_added_r <= 1'b0;
      res_found_r <= 1'b0;
      res_hi_r    <= '0;
      res_lo_r    <= '0;
    end else if (cmd.commit_get) begin
      res_added_r <= 1'b0;
      res_found_r <= ent_nz;
      res_hi_r    <= ent_hi;
      res_lo_r    <= ent_lo;
    end
    if (cmd.load_out) begin
      out_added_r <= res_added_r;
      out_found_r <= res_found_r;
      out_hi_r    <= res_hi_r;
      out_lo_r    <= res_lo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      vld_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.scan_rd;
      if (cmd.accept) begin
        idx_r <= '0;
      end else if (cmd.scan_rd) begin
        idx_r <= wrap_inc(idx_r);
      end
      if (cmd.commit_add) begin
        vld_r[wr_ptr_r] <= 1'b1;
        wr_ptr_r        <= wrap_inc(wr_ptr_r);
      end
      if (cmd.commit_get && ent_nz) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_added     = out_added_r;
  assign out_found     = out_found_r;
  assign out_flow_high = out_hi_r;
  assign out_flow_low  = out_lo_r;

  a_wr_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_ptr_r <= LAST_IDX && rd_ptr_r <= LAST_IDX)
    else $error("table pointer out of range");

  a_no_overwrite_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid_r && !out_ready))
    else $error("result loaded over a pending transfer");

  a_single_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.commit_add, cmd.commit_dup, cmd.commit_get}) <= 1)
    else $error("more than one commit in a cycle");

endmodule
